### hw/rtl/tmtl_pkg.sv
// shared types and constants for the tolerance match table lookup
`default_nettype none

package tmtl_pkg;

	localparam int unsigned TABLE_ENTRIES = 2048;
	localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned TOL_W         = 20;
	localparam int unsigned IDX_W         = 11;
	localparam int unsigned DIFF_W        = DATA_W + 1;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(52);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic signed [DATA_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] entry_index;
		coord_t           pos_x;
		coord_t           pos_y;
		coord_t           pos_z;
		coord_t           tex_u;
		coord_t           tex_v;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
		coord_t           out_u;
		coord_t           out_v;
	} rsp_t;

	typedef struct packed {
		logic   valid;
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t u;
		coord_t v;
	} entry_t;

	// status of the compare unit toward the sequencer
	typedef struct packed {
		logic              busy;
		logic              hit;
		logic [ADDR_W-1:0] idx;
		coord_t            u;
		coord_t            v;
	} mres_t;

endpackage

`default_nettype wire

### hw/rtl/tmtl_ifs.sv
// handshake channel interfaces for request, response and configuration
`default_nettype none

interface tmtl_req_if;
	logic           valid;
	logic           ready;
	tmtl_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tmtl_rsp_if;
	logic           valid;
	logic           ready;
	tmtl_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tmtl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tmtl_pkg::TOL_W-1:0]     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/tmtl_table.sv
// entry table memory with a clearing pass after reset
`default_nettype none

module tmtl_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [tmtl_pkg::ADDR_W-1:0]   waddr,
	input  wire tmtl_pkg::entry_t              wdata,
	input  wire logic                          re,
	input  wire logic [tmtl_pkg::ADDR_W-1:0]   raddr,
	output tmtl_pkg::entry_t                   rdata,
	output logic                               clr_busy
);
	import tmtl_pkg::*;

	entry_t            mem [TABLE_ENTRIES];
	logic [CNT_W-1:0]  clr_cnt_q;

	assign clr_busy = (clr_cnt_q != CNT_W'(TABLE_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clr_busy) begin
			clr_cnt_q <= clr_cnt_q + CNT_W'(1);
		end
	end

	// clear sweep has the write port until it is done
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem[clr_cnt_q[ADDR_W-1:0]] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tmtl_match.sv
// shared compare unit: one table entry per cycle against the query position
`default_nettype none

module tmtl_match (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_vld,
	input  wire logic [tmtl_pkg::ADDR_W-1:0]   in_idx,
	input  wire tmtl_pkg::entry_t              entry,
	input  wire tmtl_pkg::coord_t              qx,
	input  wire tmtl_pkg::coord_t              qy,
	input  wire tmtl_pkg::coord_t              qz,
	input  wire logic [tmtl_pkg::TOL_W-1:0]    tol,
	output tmtl_pkg::mres_t                    res
);
	import tmtl_pkg::*;

	logic              vld_s2;
	logic [ADDR_W-1:0] idx_s2;
	diff_t             dx_s2, dy_s2, dz_s2;
	coord_t            u_s2, v_s2;
	diff_t             tol_pos, tol_neg;
	logic              close_x, close_y, close_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= in_vld && entry.valid;
		end
	end

	// exact 33-bit differences, registered ahead of the compare
	always_ff @(posedge clk) begin
		dx_s2  <= DIFF_W'(qx) - DIFF_W'(entry.x);
		dy_s2  <= DIFF_W'(qy) - DIFF_W'(entry.y);
		dz_s2  <= DIFF_W'(qz) - DIFF_W'(entry.z);
		u_s2   <= entry.u;
		v_s2   <= entry.v;
		idx_s2 <= in_idx;
	end

	// |d| < t written as -t < d < t
	assign tol_pos = diff_t'({{(DIFF_W-TOL_W){1'b0}}, tol});
	assign tol_neg = -tol_pos;
	assign close_x = (dx_s2 < tol_pos) && (dx_s2 > tol_neg);
	assign close_y = (dy_s2 < tol_pos) && (dy_s2 > tol_neg);
	assign close_z = (dz_s2 < tol_pos) && (dz_s2 > tol_neg);

	assign res.busy = vld_s2;
	assign res.hit  = vld_s2 && close_x && close_y && close_z;
	assign res.idx  = idx_s2;
	assign res.u    = u_s2;
	assign res.v    = v_s2;

endmodule

`default_nettype wire

### hw/rtl/tolerance_match_table_lookup.sv
// top level of the tolerance match table lookup: sequencer, registers and channels
//
// keeps a table of 2048 entries, each a signed Q11.20 position (x, y, z) with a
// texture pair (u, v). a load transaction (req_type 0) writes one entry and marks
// it valid; it gives no response. a query transaction (req_type 1) walks the
// table from index 0 upward through a single compare unit, one entry per cycle,
// and stops at the first valid entry whose every axis lies strictly within
// match_tolerance of the query. the response carries found, the index and
// (u, v) of that entry, or all zeros when nothing matched. requests are not
// taken while a query runs or its response waits to be loaded into the output
// register. after reset the table runs a clearing pass over all 2048 entries
// during which no request is taken; the tolerance register (reset 52, about
// 0.00005) can be written at any time the block is idle.
`default_nettype none

module tolerance_match_table_lookup (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmtl_req_if.sink    req,
	tmtl_rsp_if.source  rsp,
	tmtl_cfg_if.sink    cfg
);
	import tmtl_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [TOL_W-1:0]  tol_q;
	coord_t            qx_q, qy_q, qz_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	rsp_t              pend_q;
	logic              rsp_vld_q;
	rsp_t              rsp_q;

	logic              clr_busy;
	logic              req_acc;
	logic              tbl_we;
	entry_t            tbl_wdata;
	logic              rd_issue;
	entry_t            tbl_rdata;
	mres_t             mres;
	logic              scan_end;
	logic              rsp_free;

	// ---------------------------------------------------------------
	// channel handshakes
	// ---------------------------------------------------------------
	assign req.ready = (state_q == ST_IDLE) && !clr_busy;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;
	assign rsp_free  = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			tol_q <= cfg.data;
		end
	end

	// ---------------------------------------------------------------
	// table: loads write straight in, scans read one entry per cycle
	// ---------------------------------------------------------------
	assign tbl_we          = req_acc && (req.data.req_type == REQ_LOAD);
	assign tbl_wdata.valid = 1'b1;
	assign tbl_wdata.x     = req.data.pos_x;
	assign tbl_wdata.y     = req.data.pos_y;
	assign tbl_wdata.z     = req.data.pos_z;
	assign tbl_wdata.u     = req.data.tex_u;
	assign tbl_wdata.v     = req.data.tex_v;

	// keep issuing reads until the table is exhausted or a hit comes back
	assign rd_issue = (state_q == ST_SCAN) && (rd_cnt_q != CNT_W'(TABLE_ENTRIES)) &&
		!mres.hit;

	tmtl_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (tbl_we),
		.waddr    (req.data.entry_index),
		.wdata    (tbl_wdata),
		.re       (rd_issue),
		.raddr    (rd_cnt_q[ADDR_W-1:0]),
		.rdata    (tbl_rdata),
		.clr_busy (clr_busy)
	);

	// read data comes back registered; track which index it is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[ADDR_W-1:0];
	end

	// ---------------------------------------------------------------
	// compare unit, shared by every entry of the scan
	// ---------------------------------------------------------------
	tmtl_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s1),
		.in_idx (idx_s1),
		.entry  (tbl_rdata),
		.qx     (qx_q),
		.qy     (qy_q),
		.qz     (qz_q),
		.tol    (tol_q),
		.res    (mres)
	);

	// no match: all reads issued and nothing left in flight
	assign scan_end = (rd_cnt_q == CNT_W'(TABLE_ENTRIES)) && !vld_s1 && !mres.busy;

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && (req.data.req_type == REQ_QUERY)) begin
						state_q  <= ST_SCAN;
						rd_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					if (mres.hit || scan_end) begin
						state_q <= ST_EMIT;
					end else if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (rsp_free) begin
						rsp_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query position and pending result
	always_ff @(posedge clk) begin
		if (req_acc) begin
			qx_q <= req.data.pos_x;
			qy_q <= req.data.pos_y;
			qz_q <= req.data.pos_z;
		end
		if (state_q == ST_SCAN) begin
			if (mres.hit) begin
				pend_q.found       <= 1'b1;
				pend_q.match_index <= IDX_W'(mres.idx);
				pend_q.out_u       <= mres.u;
				pend_q.out_v       <= mres.v;
			end else if (scan_end) begin
				pend_q <= '0;
			end
		end
		if ((state_q == ST_EMIT) && rsp_free) begin
			rsp_q <= pend_q;
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_no_req_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req.ready)
		else $error("request taken during table clear");

	a_query_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.data.req_type == REQ_QUERY)) |=> (state_q == ST_SCAN))
		else $error("accepted query did not start a scan");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == ST_EMIT))
		else $error("response raised outside the emit step");

	a_no_read_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_cnt_q < CNT_W'(TABLE_ENTRIES)))
		else $error("table read beyond last entry");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the tolerance match table lookup

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tmtl_pkg::*;

	localparam logic [TOL_W-1:0] TOL_MAX = '1;
	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	// long receiver hold-off, enough to back the block up into its request port
	localparam int HOLD_CYCLES   = 6000;
	// cycles allowed after the last response for a load still in flight
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 53;
	localparam int RECENT_POINTS = 48;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	logic clk;
	logic arst_n;

	tmtl_req_if req_ch();
	tmtl_rsp_if rsp_ch();
	tmtl_cfg_if cfg_ch();

	tolerance_match_table_lookup uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the lookup table and the tolerance register
	coord_t           tbl_x [TABLE_ENTRIES];
	coord_t           tbl_y [TABLE_ENTRIES];
	coord_t           tbl_z [TABLE_ENTRIES];
	coord_t           tbl_u [TABLE_ENTRIES];
	coord_t           tbl_v [TABLE_ENTRIES];
	bit               tbl_valid [TABLE_ENTRIES];
	logic [TOL_W-1:0] tol_now;

	req_t   request_backlog[$];  // requests waiting for the driver
	rsp_t   answers_due[$];      // predicted lookup answers, oldest first
	point_t recent_points[$];    // positions recently loaded, targets for near queries

	int   errors;
	int   send_gap;
	int   recv_gap;
	bit   no_idle;
	bit   hold_armed;
	bit   long_hold;
	rsp_t want;

	// per-axis check, done wide so that a full-range difference cannot wrap
	function automatic bit axis_near(coord_t a, coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return d < longint'(tol_now);
	endfunction

	// lowest valid slot within tolerance on all three axes, or all zeros
	function automatic rsp_t search_table(coord_t qx, coord_t qy, coord_t qz);
		rsp_t r;
		r = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i] && axis_near(qx, tbl_x[i]) && axis_near(qy, tbl_y[i]) &&
			    axis_near(qz, tbl_z[i])) begin
				r.found       = 1'b1;
				r.match_index = IDX_W'(i);
				r.out_u       = tbl_u[i];
				r.out_v       = tbl_v[i];
				return r;
			end
		end
		return r;
	endfunction

	// update the shadow table for a load, or predict the answer of a query
	function automatic void apply_request(req_t r);
		if (r.req_type == REQ_LOAD) begin
			tbl_x[r.entry_index]     = r.pos_x;
			tbl_y[r.entry_index]     = r.pos_y;
			tbl_z[r.entry_index]     = r.pos_z;
			tbl_u[r.entry_index]     = r.tex_u;
			tbl_v[r.entry_index]     = r.tex_v;
			tbl_valid[r.entry_index] = 1'b1;
		end else begin
			answers_due.push_back(search_table(r.pos_x, r.pos_y, r.pos_z));
		end
	endfunction

	function automatic void queue_load(int idx, coord_t x, coord_t y, coord_t z,
	                                   coord_t u, coord_t v);
		req_t   r;
		point_t p;
		r.req_type    = REQ_LOAD;
		r.entry_index = IDX_W'(idx);
		r.pos_x       = x;
		r.pos_y       = y;
		r.pos_z       = z;
		r.tex_u       = u;
		r.tex_v       = v;
		request_backlog.push_back(r);
		p.x = x;
		p.y = y;
		p.z = z;
		recent_points.push_back(p);
		if (recent_points.size() > RECENT_POINTS)
			void'(recent_points.pop_front());
	endfunction

	// index and texture fields of a query are don't-care, so they get noise
	function automatic void queue_query(coord_t x, coord_t y, coord_t z);
		req_t r;
		r.req_type    = REQ_QUERY;
		r.entry_index = IDX_W'($urandom);
		r.pos_x       = x;
		r.pos_y       = y;
		r.pos_z       = z;
		r.tex_u       = coord_t'($urandom);
		r.tex_v       = coord_t'($urandom);
		request_backlog.push_back(r);
	endfunction

	// half full range, half a tight cluster around zero so entries overlap
	function automatic coord_t pick_coord();
		if ($urandom_range(0, 1))
			return coord_t'($urandom);
		return coord_t'(int'($urandom_range(0, 400)) - 200);
	endfunction

	// move a coordinate by up to the tolerance, sometimes right onto the bound
	function automatic coord_t nudge(coord_t c, logic [TOL_W-1:0] tol);
		int off;
		case ($urandom_range(0, 3))
			0: off = 0;
			1: off = int'($urandom_range(0, tol));
			2: off = (tol == 0) ? 0 : int'(tol) - 1;
			default: off = int'(tol);
		endcase
		if ($urandom_range(0, 1))
			off = -off;
		return c + coord_t'(off);
	endfunction

	// mostly loads into low slots and queries aimed at loaded positions
	function automatic void queue_random_item(logic [TOL_W-1:0] tol);
		point_t p;
		int     idx;
		int     pick;
		pick = $urandom_range(0, 99);
		if (pick < 40 || recent_points.size() == 0) begin
			idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31)
			                                  : $urandom_range(0, TABLE_ENTRIES - 1);
			queue_load(idx, pick_coord(), pick_coord(), pick_coord(),
			           coord_t'($urandom), coord_t'($urandom));
		end else if (pick < 80) begin
			p = recent_points[$urandom_range(0, recent_points.size() - 1)];
			queue_query(nudge(p.x, tol), nudge(p.y, tol), nudge(p.z, tol));
		end else begin
			queue_query(pick_coord(), pick_coord(), pick_coord());
		end
	endfunction

	// one transaction on the config channel; only called with the block idle
	task automatic write_tolerance(logic [TOL_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		tol_now = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// sampled on the falling edge so the driver and monitor have settled
	task automatic wait_idle();
		while (request_backlog.size() != 0 || req_ch.valid || answers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver: takes the next pending request once the current one
	// is accepted, with random idle bursts in between
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap     <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				apply_request(req_ch.data);
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap != 0) begin
					send_gap     <= send_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (!no_idle && request_backlog.size() != 0 &&
				             $urandom_range(0, 7) == 0) begin
					send_gap     <= $urandom_range(0, 2);
					req_ch.valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					req_ch.data  <= request_backlog.pop_front();
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: checks each transaction against the oldest prediction,
	// and stalls in random bursts or for the whole long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap     <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (answers_due.size() == 0) begin
					$error("response with no query outstanding, match_index %0d",
					       rsp_ch.data.match_index);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (rsp_ch.data.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.data.found);
						errors++;
					end
					if (rsp_ch.data.match_index !== want.match_index) begin
						$error("match_index: expected %0d, got %0d",
						       want.match_index, rsp_ch.data.match_index);
						errors++;
					end
					if (rsp_ch.data.out_u !== want.out_u) begin
						$error("out_u: expected %0d, got %0d", want.out_u, rsp_ch.data.out_u);
						errors++;
					end
					if (rsp_ch.data.out_v !== want.out_v) begin
						$error("out_v: expected %0d, got %0d", want.out_v, rsp_ch.data.out_v);
						errors++;
					end
				end
			end
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap     <= recv_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				recv_gap     <= $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// long hold-off on the response side while requests keep coming
	initial begin
		long_hold = 1'b0;
		wait (hold_armed);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// watchdog, far beyond every query missing with the receiver stalling
	initial begin
		#(40_000_000);
		$display("tolerance_match_table_lookup verification failed");
		$finish;
	end

	initial begin
		logic [TOL_W-1:0] phase_tol;

		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		errors       = 0;
		send_gap     = 0;
		recv_gap     = 0;
		no_idle      = 1'b0;
		hold_armed   = 1'b0;
		tol_now      = TOL_RESET;
		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset tolerance
		queue_query(0, 0, 0);                                    // empty table
		queue_load(0, 0, 0, 0, COORD_MIN, COORD_MAX);
		queue_load(TABLE_ENTRIES - 1, COORD_MAX, COORD_MIN, -1, COORD_MAX, COORD_MIN);
		queue_query(51, -51, 0);                                 // just inside
		queue_query(52, 0, 0);                                   // on the bound
		queue_query(0, 0, -52);
		queue_query(COORD_MAX, COORD_MIN, -1);                   // top slot, exact
		queue_query(COORD_MIN, COORD_MIN, -1);                   // would wrap to 1 in 32 bits
		queue_query(COORD_MAX - 51, COORD_MIN + 51, 50);
		queue_load(0, 1000, 1000, 1000, 32'sh1234_5678, -5);    // overwrite a live slot
		queue_query(1000, 1000, 1000);
		queue_query(0, 0, 0);
		queue_load(5, 300, 300, 300, 11, 12);
		queue_load(9, 310, 290, 300, 21, 22);
		queue_query(305, 295, 300);                              // both match, lower wins
		queue_load(11'h555, 5000, 5000, 5000, -1, 1);
		queue_load(11'h2AA, 5000, 5000, 5000, 2, -2);
		queue_query(5000, 5000, 5000);
		queue_load(1024, -7000, -7000, -7000, 77, -77);
		queue_query(-7010, -6990, -7000);
		wait_idle();

		// zero tolerance: even an exact position misses
		write_tolerance('0);
		queue_query(1000, 1000, 1000);
		queue_query(300, 300, 300);
		wait_idle();

		// widest tolerance, one step inside and right on the bound
		write_tolerance(TOL_MAX);
		queue_query(1000 + int'(TOL_MAX) - 1, 1000 - int'(TOL_MAX) + 1, 1000);
		queue_query(COORD_MAX - int'(TOL_MAX), COORD_MIN, -1);
		wait_idle();

		// tolerance of one: exact positions only
		write_tolerance(1);
		queue_query(300, 300, 300);
		queue_query(301, 300, 300);
		wait_idle();

		// random phases, each under its own tolerance; the last runs without idling
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: phase_tol = TOL_W'($urandom_range(1, 2000));
				1: phase_tol = TOL_W'($urandom);
				2: phase_tol = TOL_W'($urandom_range(1, 64));
				3: phase_tol = TOL_MAX;
				default: phase_tol = TOL_RESET;
			endcase
			write_tolerance(phase_tol);
			if (p == 4) begin
				@(posedge clk);
				no_idle <= 1'b1;
			end
			repeat (PHASE_ITEMS) queue_random_item(phase_tol);
			if (p == 0)
				hold_armed = 1'b1;
			wait_idle();
		end

		if (errors == 0)
			$display("tolerance_match_table_lookup verification clean");
		else
			$display("tolerance_match_table_lookup verification failed");
		$finish;
	end

endmodule
